// ===== sv/utxep_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utxep_pkg
// Types and constants shared by the even-parity serial transmitter.
// ----------------------------------------------------------------------------
package utxep_pkg;

   localparam int unsigned TICK_W  = 16;
   localparam int unsigned IDLE_W  = 4;
   localparam int unsigned POS_W   = 5;
   localparam int unsigned DATA_W  = 8;
   localparam int unsigned CSR_W   = 16;

   localparam logic [TICK_W-1:0] BASE_TICKS          = 16'd1093;
   localparam logic [TICK_W-1:0] RESET_TICKS_PER_BIT = 16'(2 * BASE_TICKS);
   localparam logic [IDLE_W-1:0] RESET_IDLE_BITS     = 4'd5;
   localparam logic [POS_W-1:0]  BITS_AFTER_IDLE     = 5'd10;
   localparam logic [POS_W-1:0]  REL_START           = 5'd0;
   localparam logic [POS_W-1:0]  REL_LAST_DATA       = 5'd8;
   localparam logic [POS_W-1:0]  REL_PARITY          = 5'd9;

   typedef enum logic [0:0] {
      CMD_TICK = 1'b0,
      CMD_LOAD = 1'b1
   } cmd_type;

   typedef enum logic [0:0] {
      CSR_TICKS_PER_BIT = 1'b0,
      CSR_IDLE_BITS     = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic              command;
      logic [DATA_W-1:0] data_byte;
   } req_type;

   typedef struct packed {
      logic tx_line;
      logic busy_res;
      logic frame_done;
      logic rejected;
   } rsp_type;

   typedef struct packed {
      logic [TICK_W-1:0] ticks_per_bit;
      logic [IDLE_W-1:0] idle_bits;
   } cfg_type;

endpackage
`default_nettype wire

// ===== sv/utxep_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utxep_core
// Frame state and bit timing; advances one tick per accepted item and
// produces that tick's line level and flags.
// ----------------------------------------------------------------------------
module utxep_core
   import utxep_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step,
   input  wire req_type req,
   input  wire cfg_type cfg,
   output rsp_type      rsp
);

   logic [POS_W-1:0]  bit_position_ff, bit_position_in;
   logic [TICK_W-1:0] tick_count_ff, tick_count_in;
   logic [DATA_W-1:0] shift_byte_ff, shift_byte_in;
   logic              parity_bit_ff, parity_bit_in;
   logic              sending_ff, sending_in;

   logic              load;
   logic [POS_W-1:0]  pos;
   logic [TICK_W-1:0] cnt;
   logic [DATA_W-1:0] sbyte;
   logic              par;
   logic [TICK_W-1:0] tpb;
   logic [POS_W-1:0]  idle_ext;
   logic [POS_W-1:0]  rel;
   logic [POS_W-1:0]  rel_m1;
   logic [TICK_W:0]   cnt_next;
   logic              level;
   logic              bit_end;
   logic              last_bit;

   always_comb begin
      load     = (req.command == CMD_LOAD) && !sending_ff;
      pos      = load ? '0 : bit_position_ff;
      cnt      = load ? '0 : tick_count_ff;
      sbyte    = load ? req.data_byte : shift_byte_ff;
      par      = load ? ^req.data_byte : parity_bit_ff;
      tpb      = (cfg.ticks_per_bit == '0) ? TICK_W'(1) : cfg.ticks_per_bit;
      idle_ext = POS_W'(cfg.idle_bits);
      rel      = pos - idle_ext;
      rel_m1   = rel - POS_W'(1);
      cnt_next = {1'b0, cnt} + (TICK_W+1)'(1);
      bit_end  = cnt_next >= {1'b0, tpb};
      last_bit = pos >= (idle_ext + BITS_AFTER_IDLE);

      priority if (pos < idle_ext) begin
         level = 1'b1;
      end else if (rel == REL_START) begin
         level = 1'b0;
      end else if (rel <= REL_LAST_DATA) begin
         level = sbyte[rel_m1[2:0]];
      end else if (rel == REL_PARITY) begin
         level = par;
      end else begin
         level = 1'b1;
      end

      rsp.tx_line    = 1'b1;
      rsp.busy_res   = 1'b0;
      rsp.frame_done = 1'b0;
      rsp.rejected   = (req.command == CMD_LOAD) && sending_ff;

      bit_position_in = pos;
      tick_count_in   = cnt;
      shift_byte_in   = sbyte;
      parity_bit_in   = par;
      sending_in      = sending_ff || load;

      if (sending_ff || load) begin
         rsp.tx_line  = level;
         rsp.busy_res = 1'b1;
         if (bit_end) begin
            tick_count_in = '0;
            if (last_bit) begin
               rsp.frame_done  = 1'b1;
               sending_in      = 1'b0;
               bit_position_in = '0;
            end else begin
               bit_position_in = pos + POS_W'(1);
            end
         end else begin
            tick_count_in = cnt_next[TICK_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_position_ff <= '0;
         tick_count_ff   <= '0;
         shift_byte_ff   <= '0;
         parity_bit_ff   <= 1'b0;
         sending_ff      <= 1'b0;
      end else if (step) begin
         bit_position_ff <= bit_position_in;
         tick_count_ff   <= tick_count_in;
         shift_byte_ff   <= shift_byte_in;
         parity_bit_ff   <= parity_bit_in;
         sending_ff      <= sending_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/uart_tx_even_parity.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uart_tx_even_parity
// Serial transmitter, 8 data bits, even parity, one stop bit.
// ----------------------------------------------------------------------------
// Each accepted item is one tick of the bit clock and returns one result in the
// next cycle through the result register; a new item is taken every cycle
// while the result side keeps up (req_ready stays high when the result
// register is empty or being drained). A load item starts a frame when idle:
// idle_bits high periods, start, eight data bits LSB first, parity, stop, each
// ticks_per_bit ticks long. Register writes take effect on the next item.
// ----------------------------------------------------------------------------
module uart_tx_even_parity
   import utxep_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire req_type             req_item,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output rsp_type                  rsp_item,
   input  wire logic                csr_we,
   input  wire logic                csr_index,
   input  wire logic [CSR_W-1:0]    csr_wdata
);

   cfg_type cfg_ff;
   rsp_type rsp_item_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_step;
   logic    step;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   utxep_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (req_item),
      .cfg   (cfg_ff),
      .rsp   (rsp_step)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticks_per_bit <= RESET_TICKS_PER_BIT;
         cfg_ff.idle_bits     <= RESET_IDLE_BITS;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_TICKS_PER_BIT: cfg_ff.ticks_per_bit <= csr_wdata[TICK_W-1:0];
            CSR_IDLE_BITS:     cfg_ff.idle_bits     <= csr_wdata[IDLE_W-1:0];
            default:           cfg_ff               <= cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_item_ff <= rsp_step;
      end
   end

endmodule
`default_nettype wire

// ===== tb/sv/tb_uart_tx_even_parity.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_uart_tx_even_parity
// Self-checking bench for the even-parity serial transmitter.
// ----------------------------------------------------------------------------
// A queue-fed driver offers tick and load items, and a monitor checks every
// result against an item-level predictor of the line, busy, frame-end and
// reject flags. Bit time and idle length are changed between phases, often
// in the middle of a frame. Both channels idle in random bursts, and the
// result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_uart_tx_even_parity;
   timeunit 1ns;
   timeprecision 1ps;
   import utxep_pkg::*;

   localparam int ITEM_TARGET  = 1230;
   localparam int LONG_HOLD    = 300;
   localparam int QUIET_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 20;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_item  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_item;
   logic             csr_we    = 1'b0;
   logic             csr_index = 1'b0;
   logic [CSR_W-1:0] csr_wdata = '0;

   // predictor state and register copies
   logic [TICK_W-1:0] set_ticks;
   logic [IDLE_W-1:0] set_idle;
   logic [POS_W-1:0]  frame_pos;
   logic [TICK_W-1:0] bit_ticks;
   logic [DATA_W-1:0] frame_byte;
   logic              frame_parity;
   bit                frame_active;

   req_type pending_items[$];
   rsp_type expected_results[$];

   bit item_taken;
   bit send_idle_on = 1'b1;
   bit recv_idle_on = 1'b1;
   int send_gap;
   int recv_gap;
   int hold_left;
   int long_hold_requests;
   int long_hold_served;
   int quiet_cycles;
   int mismatches;
   int items_queued;
   int items_taken;
   int frames_sent;
   int loads_taken;
   int loads_rejected;
   int csr_writes;

   uart_tx_even_parity DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic rsp_type tx_tick(req_type it);
      rsp_type     r;
      int unsigned ticks_eff;
      int          rel;
      r = '{tx_line: 1'b1, busy_res: 1'b0, frame_done: 1'b0, rejected: 1'b0};
      if (it.command == CMD_LOAD) begin
         if (frame_active) begin
            r.rejected = 1'b1;
            loads_rejected++;
         end else begin
            frame_byte   = it.data_byte;
            frame_parity = ^it.data_byte;
            frame_pos    = '0;
            bit_ticks    = '0;
            frame_active = 1'b1;
            loads_taken++;
         end
      end
      if (frame_active) begin
         ticks_eff = (set_ticks == '0) ? 1 : int'(set_ticks);
         rel = int'(frame_pos) - int'(set_idle);
         if (rel < 0)
            r.tx_line = 1'b1;
         else if (rel == int'(REL_START))
            r.tx_line = 1'b0;
         else if (rel <= int'(REL_LAST_DATA))
            r.tx_line = frame_byte[rel-1];
         else if (rel == int'(REL_PARITY))
            r.tx_line = frame_parity;
         else
            r.tx_line = 1'b1;
         r.busy_res = 1'b1;
         if (int'(bit_ticks) + 1 >= ticks_eff) begin
            bit_ticks = '0;
            if (int'(frame_pos) >= int'(set_idle) + int'(BITS_AFTER_IDLE)) begin
               r.frame_done = 1'b1;
               frame_active = 1'b0;
               frame_pos    = '0;
               frames_sent++;
            end else begin
               frame_pos = frame_pos + 1'b1;
            end
         end else begin
            bit_ticks = bit_ticks + 1'b1;
         end
      end
      return r;
   endfunction

   // sample, check and predict at the rising edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         set_ticks    = RESET_TICKS_PER_BIT;
         set_idle     = RESET_IDLE_BITS;
         frame_pos    = '0;
         bit_ticks    = '0;
         frame_byte   = '0;
         frame_parity = 1'b0;
         frame_active = 1'b0;
         item_taken   = 1'b0;
         quiet_cycles = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result line %b busy %b done %b rejected %b",
                        $time, rsp_item.tx_line, rsp_item.busy_res,
                        rsp_item.frame_done, rsp_item.rejected);
            end else begin
               want = expected_results.pop_front();
               if (rsp_item !== want) begin
                  mismatches++;
                  $display({"%0t: mismatch, expected line %b busy %b done %b rejected %b,",
                            " got line %b busy %b done %b rejected %b"},
                           $time, want.tx_line, want.busy_res, want.frame_done,
                           want.rejected, rsp_item.tx_line, rsp_item.busy_res,
                           rsp_item.frame_done, rsp_item.rejected);
               end
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_TICKS_PER_BIT)
               set_ticks = csr_wdata[TICK_W-1:0];
            else
               set_idle = csr_wdata[IDLE_W-1:0];
         end
         item_taken = req_valid && req_ready;
         if (item_taken) begin
            expected_results.push_back(tx_tick(req_item));
            items_taken++;
         end
         if (item_taken || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
   end

   // item driver
   always @(negedge clock) begin
      logic    next_valid;
      req_type next_item;
      next_valid = req_valid;
      next_item  = req_item;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || item_taken) begin
         if (send_gap != 0) begin
            send_gap--;
            next_valid = 1'b0;
         end else if (send_idle_on && $urandom_range(0, 9) == 0) begin
            send_gap   = $urandom_range(0, 14);
            next_valid = 1'b0;
         end else if (pending_items.size() != 0) begin
            next_item  = pending_items.pop_front();
            next_valid = 1'b1;
         end else begin
            next_valid = 1'b0;
         end
      end
      req_valid <= next_valid;
      req_item  <= next_item;
   end

   // result-side ready
   always @(negedge clock) begin
      logic next_ready;
      next_ready = 1'b1;
      if (long_hold_served != long_hold_requests) begin
         long_hold_served++;
         hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
         hold_left--;
         next_ready = 1'b0;
      end else if (recv_gap != 0) begin
         recv_gap--;
         next_ready = 1'b0;
      end else if (recv_idle_on && $urandom_range(0, 9) == 0) begin
         recv_gap   = $urandom_range(0, 14);
         next_ready = 1'b0;
      end
      rsp_ready <= next_ready;
   end

   task automatic push_item(input logic cmd, input logic [DATA_W-1:0] value);
      req_type it;
      it.command   = cmd;
      it.data_byte = value;
      pending_items.push_back(it);
      items_queued++;
   endtask

   task automatic push_ticks(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 7) == 0)
            push_item(CMD_LOAD, DATA_W'($urandom));
         else
            push_item(CMD_TICK, DATA_W'($urandom));
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_regs(input bit do_ticks, input logic [TICK_W-1:0] ticks,
                             input bit do_idle, input logic [IDLE_W-1:0] idle);
      if (do_ticks) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_TICKS_PER_BIT;
         csr_wdata <= CSR_W'(ticks);
         csr_writes++;
         @(negedge clock);
      end
      if (do_idle) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IDLE_BITS;
         csr_wdata <= CSR_W'(idle);
         csr_writes++;
         @(negedge clock);
      end
      csr_we <= 1'b0;
   endtask

   initial begin
      while (quiet_cycles < QUIET_LIMIT)
         @(posedge clock);
      $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int unsigned       ticks_eff;
      int                phase;
      int                frame_len;
      bit                do_ticks;
      bit                do_idle;
      logic [TICK_W-1:0] new_ticks;
      logic [IDLE_W-1:0] new_idle;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset timing: load, tick, load while busy
      push_item(CMD_LOAD, 8'hA5);
      push_item(CMD_TICK, 8'hFF);
      push_item(CMD_LOAD, 8'h00);
      wait_drained();
      write_regs(1'b1, 16'hFFFF, 1'b0, '0);
      push_item(CMD_TICK, 8'h00);
      push_item(CMD_TICK, 8'hFF);
      wait_drained();
      // zero bit time with the count already past it, then longest idle
      write_regs(1'b1, 16'h0000, 1'b1, 4'hF);
      for (int i = 0; i < 12; i++)
         push_item(CMD_TICK, DATA_W'(i));
      wait_drained();
      // position now beyond the stop bit
      write_regs(1'b0, '0, 1'b1, 4'h0);
      push_item(CMD_TICK, 8'h5A);
      push_item(CMD_TICK, 8'hA5);
      wait_drained();
      // load on the frame-end tick, then a new frame
      push_item(CMD_LOAD, 8'hFF);
      for (int i = 0; i < 9; i++)
         push_item(CMD_TICK, 8'h00);
      push_item(CMD_LOAD, 8'h55);
      push_item(CMD_LOAD, 8'h00);
      wait_drained();

      phase = 0;
      while (items_queued < ITEM_TARGET) begin
         phase++;
         send_idle_on = ($urandom_range(0, 3) != 0);
         recv_idle_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 19))
            0:       new_ticks = 16'h0000;
            1:       new_ticks = 16'hFFFF;
            2:       new_ticks = TICK_W'($urandom_range(256, 65535));
            3:       new_ticks = RESET_TICKS_PER_BIT;
            default: new_ticks = TICK_W'($urandom_range(1, 3));
         endcase
         case ($urandom_range(0, 5))
            0:       new_idle = 4'h0;
            1:       new_idle = 4'hF;
            default: new_idle = IDLE_W'($urandom_range(0, 15));
         endcase
         do_ticks = (set_ticks > 16'd8) || ($urandom_range(0, 2) != 0);
         do_idle  = ($urandom_range(0, 2) != 0);
         write_regs(do_ticks, new_ticks, do_idle, new_idle);
         ticks_eff = (set_ticks == '0) ? 1 : int'(set_ticks);
         if (ticks_eff > 8) begin
            push_item(CMD_LOAD, DATA_W'($urandom));
            push_ticks($urandom_range(20, 40));
         end else begin
            repeat ($urandom_range(1, 2)) begin
               frame_len = (int'(set_idle) + 11) * int'(ticks_eff);
               push_item(CMD_LOAD, DATA_W'($urandom));
               push_ticks($urandom_range(frame_len / 2, frame_len + 3));
            end
         end
         if (phase == 3)
            long_hold_requests++;
         wait_drained();
      end

      // closing stretch with steady traffic
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      write_regs(1'b1, 16'd2, 1'b1, 4'd3);
      repeat (3) begin
         push_item(CMD_LOAD, DATA_W'($urandom));
         push_ticks(28 + $urandom_range(0, 3));
      end
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Ran %0d items over %0d register writes: %0d frames sent,",
               items_taken, csr_writes, frames_sent);
      $display("%0d loads started a frame, %0d were turned away while busy.",
               loads_taken, loads_rejected);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
`default_nettype wire

// ===== files.f =====
sv/utxep_pkg.sv
sv/utxep_core.sv
sv/uart_tx_even_parity.sv
tb/sv/tb_uart_tx_even_parity.sv
